@@ src/bmhrq_pkg.sv @@
// Package for the binary max-heap ready queue.
// Holds the sizing constants, operation and status codes and the entry and command types.
// Has no dependencies.
package bmhrq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = IDX_W + 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] task_id;
  } entry_t;

  typedef struct packed {
    logic   operation;
    entry_t entry;
  } cmd_t;

  function automatic logic [4:0] fill_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] w;
    w = {5'b0, c};
    return w[4:0];
  endfunction

endpackage

@@ src/binary_max_heap_ready_queue_unit.sv @@
// Top level of the binary max-heap ready queue.
// Instantiates bmhrq_front and bmhrq_back; depends on bmhrq_pkg.
//
// Usage: each request transaction on req_valid/req_stall carries an operation
// (push of prio and task_id, or pop of the highest-priority entry) and yields
// exactly one response transaction on rsp_valid/rsp_stall with status,
// out_prio, out_task_id and the fill level after the operation.
// Requests land in a two-entry command queue, so up to two can be taken while
// an earlier one is still being processed or its response is still waiting.
// Operations run one at a time over a heap memory with one registered read
// port. A push climbs from the new leaf toward the root one level at a time,
// and a pop moves the last entry to the root and sifts it down toward a leaf.
// A full-heap push or an empty-heap pop answers without touching the heap.
// A stalled response holds its value and blocks the next operation from
// starting; the command queue keeps taking requests until it is full.
// Reset empties the heap and the command queue and drops any pending response.
module binary_max_heap_ready_queue_unit import bmhrq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       operation,
  input  logic [7:0] prio,
  input  logic [7:0] task_id,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [1:0] status,
  output logic [7:0] out_prio,
  output logic [7:0] out_task_id,
  output logic [4:0] fill
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  bmhrq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .prio      (prio),
    .task_id   (task_id),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  bmhrq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .out_prio    (out_prio),
    .out_task_id (out_task_id),
    .fill        (fill)
  );

endmodule

@@ src/bmhrq_front.sv @@
// Front end of the heap queue: accepts request transactions and queues them as commands.
// A two-entry queue lets requests be taken while the back end is busy.
// Depends on bmhrq_pkg.
module bmhrq_front import bmhrq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       operation,
  input  logic [7:0] prio,
  input  logic [7:0] task_id,
  output logic       cmd_valid,
  input  logic       cmd_take,
  output cmd_t       cmd
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] n;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  assign req_stall = n[1];
  assign cmd_valid = (n != 2'd0);
  assign cmd       = q[rp];
  assign push      = req_valid && !req_stall;
  assign pop       = cmd_valid && cmd_take;

  always_comb begin
    incoming.operation     = (operation == OP_POP) ? OP_POP : OP_PUSH;
    incoming.entry.prio    = (operation == OP_POP) ? 8'd0 : prio;
    incoming.entry.task_id = (operation == OP_POP) ? 8'd0 : task_id;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= incoming;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      n  <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      n <= n + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/bmhrq_back.sv @@
// Back end of the heap queue: runs push and pop sifts over the heap memory.
// Owns the heap storage, the entry count and the registered response.
// Depends on bmhrq_pkg.
module bmhrq_back import bmhrq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_take,
  input  cmd_t       cmd,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [1:0] status,
  output logic [7:0] out_prio,
  output logic [7:0] out_task_id,
  output logic [4:0] fill
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_UP_RD     = 4'd1;
  localparam logic [3:0] S_UP_CMP    = 4'd2;
  localparam logic [3:0] S_POP_TOP   = 4'd3;
  localparam logic [3:0] S_POP_LAST  = 4'd4;
  localparam logic [3:0] S_POP_MOVED = 4'd5;
  localparam logic [3:0] S_DN_CHK    = 4'd6;
  localparam logic [3:0] S_DN_L      = 4'd7;
  localparam logic [3:0] S_DN_R      = 4'd8;
  localparam logic [3:0] S_DN_CMP    = 4'd9;

  entry_t mem [DEPTH];
  entry_t rdata;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] cidx, cidx_next;
  entry_t           ent, ent_next;
  entry_t           top, top_next;
  entry_t           child, child_next;
  logic             rsp_valid_next;
  logic [1:0]       status_next;
  logic [7:0]       out_prio_next;
  logic [7:0]       out_task_id_next;
  logic [4:0]       fill_next;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [IDX_W-1:0] up_parent;
  logic [CW-1:0]    left_w;
  logic [CW-1:0]    right_w;
  logic [CW-1:0]    cnt_w;
  logic             has_left;
  logic             has_right;

  assign up_parent = (idx - 1'b1) >> 1;
  assign left_w    = {1'b0, idx, 1'b0} + CW'(1);
  assign right_w   = left_w + CW'(1);
  assign cnt_w     = CW'(cnt);
  assign has_left  = left_w < cnt_w;
  assign has_right = right_w < cnt_w;

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    idx_next         = idx;
    cidx_next        = cidx;
    ent_next         = ent;
    top_next         = top;
    child_next       = child;
    rsp_valid_next   = rsp_valid;
    status_next      = status;
    out_prio_next    = out_prio;
    out_task_id_next = out_task_id;
    fill_next        = fill;
    cmd_take         = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = idx;
    wr_data          = ent;

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && !rsp_valid) begin
          cmd_take = 1'b1;
          if (cmd.operation == OP_PUSH) begin
            if (cnt == CNT_W'(DEPTH)) begin
              rsp_valid_next   = 1'b1;
              status_next      = ST_FULL;
              out_prio_next    = 8'd0;
              out_task_id_next = 8'd0;
              fill_next        = fill_of(cnt);
            end else begin
              ent_next   = cmd.entry;
              idx_next   = cnt[IDX_W-1:0];
              cnt_next   = cnt + 1'b1;
              state_next = S_UP_RD;
            end
          end else begin
            if (cnt == '0) begin
              rsp_valid_next   = 1'b1;
              status_next      = ST_EMPTY;
              out_prio_next    = 8'd0;
              out_task_id_next = 8'd0;
              fill_next        = fill_of(cnt);
            end else begin
              cnt_next   = cnt - 1'b1;
              state_next = S_POP_TOP;
            end
          end
        end
      end
      S_UP_RD: begin
        if (idx == '0) begin
          wr_en            = 1'b1;
          rsp_valid_next   = 1'b1;
          status_next      = ST_OK;
          out_prio_next    = 8'd0;
          out_task_id_next = 8'd0;
          fill_next        = fill_of(cnt);
          state_next       = S_IDLE;
        end else begin
          rd_addr    = up_parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rdata.prio >= ent.prio) begin
          rsp_valid_next   = 1'b1;
          status_next      = ST_OK;
          out_prio_next    = 8'd0;
          out_task_id_next = 8'd0;
          fill_next        = fill_of(cnt);
          state_next       = S_IDLE;
        end else begin
          wr_data    = rdata;
          idx_next   = up_parent;
          state_next = S_UP_RD;
        end
      end
      S_POP_TOP: begin
        rd_addr    = '0;
        state_next = S_POP_LAST;
      end
      S_POP_LAST: begin
        top_next   = rdata;
        rd_addr    = cnt[IDX_W-1:0];
        state_next = S_POP_MOVED;
      end
      S_POP_MOVED: begin
        ent_next   = rdata;
        idx_next   = '0;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (!has_left) begin
          wr_en            = 1'b1;
          rsp_valid_next   = 1'b1;
          status_next      = ST_OK;
          out_prio_next    = top.prio;
          out_task_id_next = top.task_id;
          fill_next        = fill_of(cnt);
          state_next       = S_IDLE;
        end else begin
          rd_addr    = left_w[IDX_W-1:0];
          state_next = S_DN_L;
        end
      end
      S_DN_L: begin
        child_next = rdata;
        cidx_next  = left_w[IDX_W-1:0];
        if (has_right) begin
          rd_addr    = right_w[IDX_W-1:0];
          state_next = S_DN_R;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_R: begin
        if (rdata.prio > child.prio) begin
          child_next = rdata;
          cidx_next  = right_w[IDX_W-1:0];
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (ent.prio >= child.prio) begin
          rsp_valid_next   = 1'b1;
          status_next      = ST_OK;
          out_prio_next    = top.prio;
          out_task_id_next = top.task_id;
          fill_next        = fill_of(cnt);
          state_next       = S_IDLE;
        end else begin
          wr_data    = child;
          idx_next   = cidx;
          state_next = S_DN_CHK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    cidx        <= cidx_next;
    ent         <= ent_next;
    top         <= top_next;
    child       <= child_next;
    status      <= status_next;
    out_prio    <= out_prio_next;
    out_task_id <= out_task_id_next;
    fill        <= fill_next;
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for binary_max_heap_ready_queue_unit. Depends on bmhrq_pkg.
// It runs a directed table and then random push and pop bursts, and checks every response.
// Typed table rows give their own expected results; a heap predictor here gives the rest.
module tb_top;
  import bmhrq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_prio;
    logic [7:0] out_task_id;
    logic [4:0] fill;
  } result_t;

  typedef struct packed {
    logic       op;
    logic [7:0] p;
    logic [7:0] id;
    bit         typed;
    result_t    want;
  } row_t;

  localparam result_t UNTYPED = '0;
  localparam int N_ROWS = 25;
  localparam int N_RANDOM = 1050;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       operation = OP_PUSH;
  logic [7:0] prio = 8'h00;
  logic [7:0] task_id = 8'h00;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] out_prio;
  logic [7:0] out_task_id;
  logic [4:0] fill;

  entry_t  heap_model [DEPTH];
  int      heap_size = 0;
  result_t pending_results [$];
  int      errors = 0;
  bit      calm = 1'b0;

  row_t plan [N_ROWS] = '{
    '{OP_POP,  8'h00, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 8'h00, 5'd0}},
    '{OP_PUSH, 8'hFF, 8'hFF, 1'b1, '{ST_OK,    8'h00, 8'h00, 5'd1}},
    '{OP_POP,  8'h00, 8'h00, 1'b1, '{ST_OK,    8'hFF, 8'hFF, 5'd0}},
    '{OP_PUSH, 8'h00, 8'h00, 1'b1, '{ST_OK,    8'h00, 8'h00, 5'd1}},
    '{OP_PUSH, 8'h80, 8'h01, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h80, 8'h02, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h80, 8'h03, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h7F, 8'h04, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h01, 8'h05, 1'b0, UNTYPED},
    '{OP_PUSH, 8'hFE, 8'h06, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h80, 8'h07, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h55, 8'hAA, 1'b0, UNTYPED},
    '{OP_PUSH, 8'hAA, 8'h55, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h80, 8'h08, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h00, 8'h09, 1'b0, UNTYPED},
    '{OP_PUSH, 8'hFF, 8'h0A, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h7F, 8'h0B, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h80, 8'h0C, 1'b0, UNTYPED},
    '{OP_PUSH, 8'h10, 8'hF0, 1'b0, UNTYPED},
    '{OP_PUSH, 8'hFF, 8'hFF, 1'b1, '{ST_FULL,  8'h00, 8'h00, 5'd16}},
    '{OP_POP,  8'h00, 8'h00, 1'b0, UNTYPED},
    '{OP_POP,  8'h00, 8'h00, 1'b0, UNTYPED},
    '{OP_POP,  8'h00, 8'h00, 1'b0, UNTYPED},
    '{OP_POP,  8'hFF, 8'hFF, 1'b0, UNTYPED},
    '{OP_POP,  8'h00, 8'h00, 1'b0, UNTYPED}
  };

  binary_max_heap_ready_queue_unit uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .prio(prio), .task_id(task_id),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .out_prio(out_prio), .out_task_id(out_task_id), .fill(fill)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t heap_apply(input logic op, input entry_t e);
    result_t r;
    entry_t  moved;
    int      i;
    int      c;
    int      par;
    r = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (heap_size >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        i = heap_size;
        heap_size++;
        while (i > 0) begin
          par = (i - 1) / 2;
          if (heap_model[par].prio >= e.prio) break;
          heap_model[i] = heap_model[par];
          i = par;
        end
        heap_model[i] = e;
      end
    end else if (heap_size == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_prio = heap_model[0].prio;
      r.out_task_id = heap_model[0].task_id;
      heap_size--;
      moved = heap_model[heap_size];
      i = 0;
      while (i * 2 + 1 < heap_size) begin
        c = i * 2 + 1;
        if (c + 1 < heap_size && heap_model[c + 1].prio > heap_model[c].prio) c = c + 1;
        if (moved.prio >= heap_model[c].prio) break;
        heap_model[i] = heap_model[c];
        i = c;
      end
      heap_model[i] = moved;
    end
    r.fill = heap_size[4:0];
    return r;
  endfunction

  task automatic issue_request(input logic op, input logic [7:0] p, input logic [7:0] id,
                               input bit typed, input result_t want);
    result_t r;
    entry_t  e;
    bit      took;
    while (!calm && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    prio <= p;
    task_id <= id;
    e.prio = p;
    e.task_id = id;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      if (!req_stall) begin
        took = 1'b1;
        r = heap_apply(op, e);
        pending_results.push_back(typed ? want : r);
      end
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(99) < 11);
  end

  always @(negedge clk) begin
    result_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("response transaction with no expectation waiting");
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status);
          errors++;
        end
        if (out_prio !== w.out_prio) begin
          $error("out_prio: expected %0d, got %0d", w.out_prio, out_prio);
          errors++;
        end
        if (out_task_id !== w.out_task_id) begin
          $error("out_task_id: expected %0d, got %0d", w.out_task_id, out_task_id);
          errors++;
        end
        if (fill !== w.fill) begin
          $error("fill: expected %0d, got %0d", w.fill, fill);
          errors++;
        end
      end
    end
  end

  initial begin
    int         n;
    int         k;
    int         burst;
    int         push_pct;
    bit         narrow;
    logic       op;
    logic [7:0] p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      issue_request(plan[r].op, plan[r].p, plan[r].id, plan[r].typed, plan[r].want);
    end

    // Bursts lean toward push or pop so the fill level sweeps between empty and full.
    n = 0;
    while (n < N_RANDOM) begin
      burst = $urandom_range(40, 8);
      push_pct = $urandom_range(85, 15);
      narrow = ($urandom_range(2) == 0);
      for (k = 0; k < burst && n < N_RANDOM; k++) begin
        calm = (n >= 450 && n < 650);
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        p = narrow ? 8'($urandom_range(3) * 85) : 8'($urandom);
        issue_request(op, p, 8'($urandom), 1'b0, UNTYPED);
        n++;
      end
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
src/bmhrq_pkg.sv
src/bmhrq_front.sv
src/bmhrq_back.sv
src/binary_max_heap_ready_queue_unit.sv
bench/tb_top.sv
